### hw/rtl/perl_pkg.sv
`default_nettype none
package perl_pkg;

    // Widths of the fixed-point datapath.
    localparam int ONE_SHIFT = 24;
    localparam int OFS_W     = 26;
    localparam int GRAD_W    = 18;
    localparam int DOT_W     = 36;
    localparam int WGT_W     = 26;
    localparam int ROW_W     = 38;
    localparam int VAL_W     = 40;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_STAGES = CORDIC_STEPS / 2;

    // Hash multipliers.
    localparam logic [31:0] HASH_C1 = 32'd3284157443;
    localparam logic [31:0] HASH_C2 = 32'd1911520717;
    localparam logic [31:0] HASH_C3 = 32'd2048419325;

    // Gain-compensated CORDIC start value, Q2.30.
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // Arctangent of 2^-i in binary angle units (full turn = 2^32).
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [33:0] z;
    } cordic_t;

    function automatic logic [31:0] rot16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    // One rotation step with floor shifts.
    function automatic cordic_t cordic_iter(input cordic_t c, input int i);
        cordic_t r;
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        logic signed [33:0] at;
        xs = c.x >>> i;
        ys = c.y >>> i;
        at = $signed({2'b00, ATAN_TURNS[i]});
        if (!c.z[33])
        begin
            r.x = c.x - ys;
            r.y = c.y + xs;
            r.z = c.z - at;
        end
        else
        begin
            r.x = c.x + ys;
            r.y = c.y - xs;
            r.z = c.z + at;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/perl_point_if.sv
`default_nettype none
interface perl_point_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface
`default_nettype wire

### hw/rtl/perl_noise_if.sv
`default_nettype none
interface perl_noise_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

### hw/rtl/perl_corner.sv
`default_nettype none
// One lattice corner: hash, CORDIC gradient and dot product, 14 stages.
module perl_corner #(
    parameter int ANGLE_BITS = 10
) (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic [31:0]                         cx,
    input  wire logic [31:0]                         cy,
    input  wire logic signed [perl_pkg::OFS_W-1:0]   dx,
    input  wire logic signed [perl_pkg::OFS_W-1:0]   dy,
    output logic signed [perl_pkg::DOT_W-1:0]        dot
);
    import perl_pkg::*;

    localparam int DLY = 3 + CORDIC_STAGES + 1;
    localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    logic [31:0] a1_reg, cy1_reg, a2_reg, b2_reg, a3_reg;
    logic signed [OFS_W-1:0] dx_reg [DLY];
    logic signed [OFS_W-1:0] dy_reg [DLY];
    cordic_t cor_reg [CORDIC_STAGES];
    logic    flip_reg [CORDIC_STAGES];
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic signed [DOT_W+8:0] px_reg, py_reg;
    logic signed [DOT_W-1:0] dot_reg;

    logic [31:0] phase;
    logic        flip;
    cordic_t     cor_init;

    // Hash over three multiply stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= cx * HASH_C1;
            cy1_reg <= cy;
            b2_reg  <= (cy1_reg ^ rot16(a1_reg)) * HASH_C2;
            a2_reg  <= a1_reg;
            a3_reg  <= (a2_reg ^ rot16(b2_reg)) * HASH_C3;
        end
    end

    // Offsets ride along until the multiply stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg[0] <= dx;
            dy_reg[0] <= dy;
            for (int i = 1; i < DLY; i++)
            begin
                dx_reg[i] <= dx_reg[i-1];
                dy_reg[i] <= dy_reg[i-1];
            end
        end
    end

    // Fold the angle into the right half plane.
    always_comb
    begin
        phase      = a3_reg & PHASE_MASK;
        flip       = phase[31] ^ phase[30];
        cor_init.x = CORDIC_GAIN;
        cor_init.y = '0;
        cor_init.z = $signed({{2{phase[31] ^ flip}}, phase[31] ^ flip, phase[30:0]});
    end

    // Two rotation steps per stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cor_reg[0]  <= cordic_iter(cordic_iter(cor_init, 0), 1);
            flip_reg[0] <= flip;
            for (int k = 1; k < CORDIC_STAGES; k++)
            begin
                cor_reg[k]  <= cordic_iter(cordic_iter(cor_reg[k-1], 2*k), 2*k+1);
                flip_reg[k] <= flip_reg[k-1];
            end
        end
    end

    // Undo the fold, round to Q15, then dot product.
    logic signed [33:0] gxf, gyf, gxr, gyr;
    always_comb
    begin
        gxf = flip_reg[CORDIC_STAGES-1] ? -34'(cor_reg[CORDIC_STAGES-1].x)
                                        : 34'(cor_reg[CORDIC_STAGES-1].x);
        gyf = flip_reg[CORDIC_STAGES-1] ? -34'(cor_reg[CORDIC_STAGES-1].y)
                                        : 34'(cor_reg[CORDIC_STAGES-1].y);
        gxr = (gxf + 34'sd16384) >>> 15;
        gyr = (gyf + 34'sd16384) >>> 15;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_reg  <= gxr[GRAD_W-1:0];
            gy_reg  <= gyr[GRAD_W-1:0];
            px_reg  <= (DOT_W+9)'(dx_reg[DLY-1]) * (DOT_W+9)'(gx_reg);
            py_reg  <= (DOT_W+9)'(dy_reg[DLY-1]) * (DOT_W+9)'(gy_reg);
            dot_reg <= DOT_W'((px_reg + py_reg) >>> 9);
        end
    end

    assign dot = dot_reg;
endmodule
`default_nettype wire

### hw/rtl/perlin_noise_2d.sv
`default_nettype none
// Channel  Dir  Fields
// point    in   pos_x[31:0], pos_y[31:0]   unsigned fixed point
// noise    out  noise_value[15:0]          signed, saturated
//
// One point is taken every cycle while the output is not stalled, through twenty register
// stages; a result can be taken once its point has reached the last stage.
// The depth is set by the three hash multiplies and eight two-step CORDIC
// stages of each corner unit, followed by the blend multiplies.
// Reset clears only the valid bits; the datapath holds no state between points.
// A stall on the output freezes the whole pipeline in place.
module perlin_noise_2d #(
    parameter int FRAC_BITS     = 16,
    parameter int ANGLE_BITS    = 10,
    parameter int OUT_FRAC_BITS = 15
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    perl_point_if.sink  point,
    perl_noise_if.source noise
);
    import perl_pkg::*;

    localparam int NSTG  = 20;
    localparam int CLAT  = 14;
    localparam logic [31:0] FMASK = (32'd1 << FRAC_BITS) - 32'd1;
    localparam logic signed [OFS_W-1:0] ONE = OFS_W'(1) <<< ONE_SHIFT;

    logic en;
    logic vld_reg [NSTG];
    logic [31:0] px_reg, py_reg;

    assign en          = !vld_reg[NSTG-1] || noise.ready;
    assign point.ready = en;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= point.valid;
            for (int i = 1; i < NSTG; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= point.pos_x;
            py_reg <= point.pos_y;
        end
    end

    // Cell corners and offsets in Q24.
    logic [31:0] x0, y0, x1, y1;
    logic [23:0] fx, fy;
    logic signed [OFS_W-1:0] dx0, dy0, dx1, dy1;
    always_comb
    begin
        x0  = px_reg >> FRAC_BITS;
        y0  = py_reg >> FRAC_BITS;
        x1  = x0 + 32'd1;
        y1  = y0 + 32'd1;
        fx  = 24'((px_reg & FMASK) << (ONE_SHIFT - FRAC_BITS));
        fy  = 24'((py_reg & FMASK) << (ONE_SHIFT - FRAC_BITS));
        dx0 = $signed({2'b00, fx});
        dy0 = $signed({2'b00, fy});
        dx1 = dx0 - ONE;
        dy1 = dy0 - ONE;
    end

    logic signed [DOT_W-1:0] n00, n10, n01, n11;
    perl_corner #(.ANGLE_BITS(ANGLE_BITS)) u_c00 (.clk, .en, .cx(x0), .cy(y0),
        .dx(dx0), .dy(dy0), .dot(n00));
    perl_corner #(.ANGLE_BITS(ANGLE_BITS)) u_c10 (.clk, .en, .cx(x1), .cy(y0),
        .dx(dx1), .dy(dy0), .dot(n10));
    perl_corner #(.ANGLE_BITS(ANGLE_BITS)) u_c01 (.clk, .en, .cx(x0), .cy(y1),
        .dx(dx0), .dy(dy1), .dot(n01));
    perl_corner #(.ANGLE_BITS(ANGLE_BITS)) u_c11 (.clk, .en, .cx(x1), .cy(y1),
        .dx(dx1), .dy(dy1), .dot(n11));

    // Smoothstep weights over two stages, then delayed to match the corners.
    logic [47:0] sqx_reg, sqy_reg;
    logic [23:0] fx1_reg, fy1_reg;
    logic [WGT_W-1:0] sx_reg [2:CLAT];
    logic [WGT_W-1:0] sy_reg [2:CLAT+2];
    logic [49:0] wx, wy;
    always_comb
    begin
        wx = 50'(sqx_reg[47:24]) * 50'((26'd3 << ONE_SHIFT) - {1'b0, fx1_reg, 1'b0});
        wy = 50'(sqy_reg[47:24]) * 50'((26'd3 << ONE_SHIFT) - {1'b0, fy1_reg, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg   <= 48'(fx) * 48'(fx);
            sqy_reg   <= 48'(fy) * 48'(fy);
            fx1_reg   <= fx;
            fy1_reg   <= fy;
            sx_reg[2] <= wx[ONE_SHIFT+WGT_W-1:ONE_SHIFT];
            sy_reg[2] <= wy[ONE_SHIFT+WGT_W-1:ONE_SHIFT];
            for (int i = 3; i <= CLAT; i++)
                sx_reg[i] <= sx_reg[i-1];
            for (int i = 3; i <= CLAT + 2; i++)
                sy_reg[i] <= sy_reg[i-1];
        end
    end

    // Blend along x, then along y.
    localparam int PX_W = DOT_W + 1 + WGT_W + 1;
    localparam int PY_W = ROW_W + 1 + WGT_W + 1;
    logic signed [PX_W-1:0] p0_reg, p1_reg;
    logic signed [DOT_W-1:0] a0_reg, a1_reg;
    logic signed [ROW_W-1:0] r0_reg, r1_reg, r0d_reg;
    logic signed [PY_W-1:0] q_reg;
    logic signed [VAL_W-1:0] v_reg;
    logic signed [15:0] out_reg;
    logic signed [15:0] out_next;

    logic signed [PX_W-1:0] sxw;
    logic signed [PY_W-1:0] syw;
    logic signed [PX_W-1:0] r0w, r1w;
    logic signed [PY_W-1:0] vw;
    always_comb
    begin
        sxw = $signed(PX_W'(sx_reg[CLAT]));
        syw = $signed(PY_W'(sy_reg[CLAT+2]));
        r0w = PX_W'(a0_reg) + (p0_reg >>> ONE_SHIFT);
        r1w = PX_W'(a1_reg) + (p1_reg >>> ONE_SHIFT);
        vw  = PY_W'(r0d_reg) + (q_reg >>> ONE_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= (PX_W'(n10) - PX_W'(n00)) * sxw;
            p1_reg  <= (PX_W'(n11) - PX_W'(n01)) * sxw;
            a0_reg  <= n00;
            a1_reg  <= n01;
            r0_reg  <= r0w[ROW_W-1:0];
            r1_reg  <= r1w[ROW_W-1:0];
            q_reg   <= (PY_W'(r1_reg) - PY_W'(r0_reg)) * syw;
            r0d_reg <= r0_reg;
            v_reg   <= vw[VAL_W-1:0];
            out_reg <= out_next;
        end
    end

    // Round to the output fraction and saturate.
    localparam logic signed [VAL_W-1:0] RND = VAL_W'(1) <<< (29 - OUT_FRAC_BITS);
    logic signed [VAL_W-1:0] rq;
    always_comb
    begin
        rq = (v_reg + RND) >>> (30 - OUT_FRAC_BITS);
        if (rq > VAL_W'(32767))
            out_next = 16'sh7FFF;
        else if (rq < -VAL_W'(32768))
            out_next = 16'sh8000;
        else
            out_next = rq[15:0];
    end

    assign noise.valid       = vld_reg[NSTG-1];
    assign noise.noise_value = out_reg;

    // The input side is ready exactly when the pipeline may advance.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        point.ready == (!noise.valid || noise.ready))
        else $error("point ready does not follow the pipeline enable");

    // A frozen pipeline keeps its first and middle valid bits.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(vld_reg[0]) && $stable(vld_reg[CLAT])))
        else $error("valid bits moved during a stall");

    // An accepted point reaches stage one on the next edge.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (point.valid && point.ready) |=> vld_reg[0])
        else $error("accepted point lost at the input stage");

    // A moving pipeline shifts its valid bits by one stage.
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (vld_reg[NSTG-1] == $past(vld_reg[NSTG-2])))
        else $error("valid bit skipped the output stage");
endmodule
`default_nettype wire

### tb/sv/perlin_noise_2d_test.sv
module perlin_noise_2d_test;
    timeunit 1ns;
    timeprecision 1ps;

    import perl_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int ANGLE_BITS    = 10;
    localparam int OUT_FRAC_BITS = 15;
    localparam int PIPE_DEPTH    = 20;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint ONE_Q24 = 64'sd1 << 24;

    // Idle profiles for the sender and the receiver.
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic clk;
    logic rst_n;

    perl_point_if point ();
    perl_noise_if noise ();

    perlin_noise_2d #(
        .FRAC_BITS(FRAC_BITS),
        .ANGLE_BITS(ANGLE_BITS),
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .point(point.sink),
        .noise(noise.source)
    );

    logic signed [15:0] noise_queue[$];
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    logic hold_off_req;
    logic hold_off_done;
    int error_count = 0;
    longint cycle_count = 0;

    // Floor shift of a signed value (>>> on longint is arithmetic).
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] swap_halves(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    // Gradient (cos, sin) in Q15 for one lattice corner.
    function automatic void corner_grad(input logic [31:0] cx, input logic [31:0] cy,
                                        output longint gx, output longint gy);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] phase;
        logic [63:0] prod;
        bit flip;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        prod = 64'(cx) * 64'(HASH_C1);
        a = prod[31:0];
        b = cy ^ swap_halves(a);
        prod = 64'(b) * 64'(HASH_C2);
        b = prod[31:0];
        a = a ^ swap_halves(b);
        prod = 64'(a) * 64'(HASH_C3);
        a = prod[31:0];
        phase = a & (32'hFFFF_FFFF << (32 - ANGLE_BITS));
        flip = 0;
        if (phase >= 32'h4000_0000 && phase < 32'hC000_0000)
        begin
            flip = 1;
            phase = phase - 32'h8000_0000;
        end
        z = longint'($signed(phase));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TURNS[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TURNS[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        gx = floor_shr(x + (64'sd1 << 14), 15);
        gy = floor_shr(y + (64'sd1 << 14), 15);
    endfunction

    function automatic longint corner_dot(input logic [31:0] cx, input logic [31:0] cy,
                                          input longint dx, input longint dy);
        longint gx;
        longint gy;
        corner_grad(cx, cy, gx, gy);
        return floor_shr(dx * gx + dy * gy, 9);
    endfunction

    function automatic longint smoothstep(input longint f);
        longint f2;
        f2 = (f * f) >>> 24;
        return (f2 * (3 * ONE_Q24 - 2 * f)) >>> 24;
    endfunction

    function automatic longint lerp(input longint a0, input longint a1, input longint s);
        return a0 + floor_shr((a1 - a0) * s, 24);
    endfunction

    // Noise value at one point, rounded and saturated.
    function automatic logic signed [15:0] noise_at(input logic [31:0] px,
                                                    input logic [31:0] py);
        logic [31:0] x0;
        logic [31:0] y0;
        logic [31:0] x1;
        logic [31:0] y1;
        longint fx;
        longint fy;
        longint sx;
        longint sy;
        longint r0;
        longint r1;
        longint v;
        longint q;
        x0 = px >> FRAC_BITS;
        y0 = py >> FRAC_BITS;
        x1 = x0 + 1;
        y1 = y0 + 1;
        fx = longint'(px & ((32'd1 << FRAC_BITS) - 1)) << (24 - FRAC_BITS);
        fy = longint'(py & ((32'd1 << FRAC_BITS) - 1)) << (24 - FRAC_BITS);
        sx = smoothstep(fx);
        sy = smoothstep(fy);
        r0 = lerp(corner_dot(x0, y0, fx, fy), corner_dot(x1, y0, fx - ONE_Q24, fy), sx);
        r1 = lerp(corner_dot(x0, y1, fx, fy - ONE_Q24),
                  corner_dot(x1, y1, fx - ONE_Q24, fy - ONE_Q24), sx);
        v = lerp(r0, r1, sy);
        q = floor_shr(v + (64'sd1 << (29 - OUT_FRAC_BITS)), 30 - OUT_FRAC_BITS);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return 16'(q);
    endfunction

    // Clock.
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise.ready <= 1'b0;
            hold_off_cycles <= 0;
            hold_off_done <= 1'b0;
        end
        else if (hold_off_req && !hold_off_done)
        begin
            noise.ready <= 1'b0;
            hold_off_cycles <= 200;
            hold_off_done <= 1'b1;
        end
        else if (hold_off_cycles > 0)
        begin
            noise.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            noise.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: compares each beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && noise.valid && noise.ready)
        begin
            if (noise_queue.size() == 0)
            begin
                $error("noise_value: unexpected beat, actual %0d", noise.noise_value);
                error_count++;
            end
            else
            begin
                if (noise.noise_value !== noise_queue[0])
                begin
                    $error("noise_value: expected %0d, actual %0d",
                           noise_queue[0], noise.noise_value);
                    error_count++;
                end
                noise_queue.pop_front();
            end
        end
    end

    // Offer one point and hold it until accepted.
    task automatic send_point(input logic [31:0] px, input logic [31:0] py);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point.valid <= 1'b0;
            @(posedge clk);
        end
        point.valid <= 1'b1;
        point.pos_x <= px;
        point.pos_y <= py;
        noise_queue.push_back(noise_at(px, py));
        do
            @(posedge clk);
        while (!point.ready);
    endtask

    task automatic set_idle(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SEND || mode == IDLE_BOTH) ?
                         ((mode == IDLE_BOTH) ? 20 : 83) : 0;
        recv_stall_pct = (mode == IDLE_RECV || mode == IDLE_BOTH) ?
                         ((mode == IDLE_BOTH) ? 20 : 83) : 0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom_range(32'h0004_0000);
            1: return 32'hFFFF_FFFF - $urandom_range(32'h0004_0000);
            2: return {16'($urandom_range(16'hFFFF)), 16'h0000} | $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // Corners, fraction extremes and the far-corner wrap.
    task automatic test_directed();
        logic [31:0] pts[10] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_8000,
                                 32'h0000_FFFF, 32'h0001_0000, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'hFFFF_0000, 32'hFFFF_FFFF,
                                 32'hA5A5_5A5A};
        for (int i = 0; i < 10; i++)
            send_point(pts[i], pts[9 - i]);
        for (int i = 0; i < 10; i++)
            send_point(pts[i], pts[i]);
    endtask

    task automatic test_random(input idle_mode_t mode, input int count);
        set_idle(mode);
        for (int i = 0; i < count; i++)
            send_point(rand_coord(), rand_coord());
    endtask

    // Long receiver hold-off while points keep coming, so the pipeline fills.
    task automatic test_backpressure();
        set_idle(IDLE_NONE);
        hold_off_req <= 1'b1;
        for (int i = 0; i < 100; i++)
            send_point($urandom, $urandom);
    endtask

    task automatic drain();
        point.valid <= 1'b0;
        while (noise_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    initial
    begin
        set_idle(IDLE_NONE);
        hold_off_req = 1'b0;
        rst_n = 1'b0;
        point.valid = 1'b0;
        point.pos_x = '0;
        point.pos_y = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(IDLE_NONE, 450);
        test_random(IDLE_SEND, 450);
        test_random(IDLE_RECV, 450);
        test_random(IDLE_BOTH, 450);
        test_backpressure();
        drain();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### files.f
hw/rtl/perl_pkg.sv
hw/rtl/perl_point_if.sv
hw/rtl/perl_noise_if.sv
hw/rtl/perl_corner.sv
hw/rtl/perlin_noise_2d.sv
tb/sv/perlin_noise_2d_test.sv
